// ===== sv/bclt_pkg.sv =====
// Shared types and constants for the block cache tag engine.
// Used by bclt_cell and block_cache_lru_tags; depends on nothing.
package bclt_pkg;

    localparam int CACHE_SLOTS = 16;
    localparam int BLOCK_BYTES = 512;
    localparam int SLOT_W      = $clog2(CACHE_SLOTS);
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int TAG_W       = 16;
    localparam int STAMP_W     = 32;
    localparam int OFFSET_W    = 26;
    localparam int HDR_W       = 16;
    localparam int CFG_IDX_W   = 1;

    typedef logic [SLOT_W-1:0]  slot_idx_t;
    typedef logic [TAG_W-1:0]   tag_t;
    typedef logic [STAMP_W-1:0] stamp_t;

    // Action codes; code 3 is reserved and answered as invalid.
    localparam logic [1:0] ACT_GET   = 2'd0;
    localparam logic [1:0] ACT_MARK  = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WITH_HEADER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SIZE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_INVALID    = 3'd2,
        ST_NOT_CACHED = 3'd3,
        ST_NO_DIRTY   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    // Query broadcast to every cell while a scan runs.
    typedef struct packed {
        tag_t   blk;
        stamp_t count;
    } query_t;

    // Running search record handed from cell to cell.
    typedef struct packed {
        logic      match_found;
        slot_idx_t match_idx;
        logic      empty_found;
        slot_idx_t empty_idx;
        logic      clean_found;
        slot_idx_t clean_idx;
        stamp_t    best_age;
        logic      dirty_found;
        slot_idx_t dirty_idx;
        tag_t      dirty_tag;
    } scan_rec_t;

    // Slot update broadcast at the end of a scan.
    typedef struct packed {
        logic      en;
        slot_idx_t idx;
        logic      wr_tag;
        tag_t      tag;
        logic      wr_dirty;
        logic      dirty;
        logic      wr_stamp;
        stamp_t    stamp;
    } slot_wr_t;

endpackage

// ===== sv/bclt_cell.sv =====
// One cache slot: tag, dirty mark and use stamp, plus one stage of the search chain.
// Depends on bclt_pkg.
module bclt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  bclt_pkg::slot_idx_t cell_idx,
    input  bclt_pkg::query_t    query,
    input  logic               in_valid,
    input  bclt_pkg::scan_rec_t in_rec,
    output logic               out_valid,
    output bclt_pkg::scan_rec_t out_rec,
    input  bclt_pkg::slot_wr_t  wr
);
    import bclt_pkg::*;

    tag_t      tag_reg;
    logic      dirty_reg;
    stamp_t    stamp_reg;
    logic      valid_reg;
    scan_rec_t rec_reg;
    scan_rec_t rec_next;
    stamp_t    age;
    logic      wr_hit;

    assign age    = query.count - stamp_reg;
    assign wr_hit = wr.en && (wr.idx == cell_idx);

    // Fold this slot into the record coming from the previous cell.
    always_comb
    begin
        rec_next = in_rec;
        if (!in_rec.match_found && (tag_reg == query.blk))
        begin
            rec_next.match_found = 1'b1;
            rec_next.match_idx   = cell_idx;
        end
        if (!in_rec.empty_found && (tag_reg == '0))
        begin
            rec_next.empty_found = 1'b1;
            rec_next.empty_idx   = cell_idx;
        end
        if (!dirty_reg && (!in_rec.clean_found || (age > in_rec.best_age)))
        begin
            rec_next.clean_found = 1'b1;
            rec_next.clean_idx   = cell_idx;
            rec_next.best_age    = age;
        end
        if (!in_rec.dirty_found && dirty_reg)
        begin
            rec_next.dirty_found = 1'b1;
            rec_next.dirty_idx   = cell_idx;
            rec_next.dirty_tag   = tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg   <= '0;
            dirty_reg <= 1'b0;
            stamp_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
            if (wr_hit && wr.wr_tag)
            begin
                tag_reg <= wr.tag;
            end
            if (wr_hit && wr.wr_dirty)
            begin
                dirty_reg <= wr.dirty;
            end
            if (wr_hit && wr.wr_stamp)
            begin
                stamp_reg <= wr.stamp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            rec_reg <= rec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rec   = rec_reg;

endmodule

// ===== sv/block_cache_lru_tags.sv =====
// Top level of the block cache tag engine: command port, config registers, chain of slot cells.
// Depends on bclt_pkg and bclt_cell.

// An item is taken when start is high and busy is low. A search token walks the row of
// CACHE_SLOTS slot cells, one cell per cycle, and the slot update and result follow in the
// cycle after it leaves the last cell. done pulses and busy drops in that same cycle, so no
// new item is taken before the last one is done. The result ports are valid only while done
// is high and there is no way to hold them; capture them in that cycle. The use counter
// advances once per item, errors included. Configuration writes are always ready and belong
// in idle periods only.
module block_cache_lru_tags (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     action,
    input  logic [15:0]                    block_number,
    output logic                           done,
    output logic [3:0]                     slot,
    output logic [15:0]                    block_out,
    output logic                           hit,
    output logic                           load_needed,
    output logic                           writeback_needed,
    output logic [25:0]                    byte_offset,
    output logic [2:0]                     status,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bclt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data
);
    import bclt_pkg::*;

    state_t    state_reg;
    state_t    state_next;
    logic      inject_reg;
    logic [1:0] action_reg;
    tag_t      blk_reg;
    stamp_t    counter_reg;
    logic      with_header_reg;
    logic [HDR_W-1:0] header_size_reg;
    logic      done_reg;

    logic [3:0]          slot_reg;
    tag_t                block_out_reg;
    logic                hit_reg;
    logic                load_reg;
    logic                wb_reg;
    logic [OFFSET_W-1:0] offset_reg;
    status_t             status_reg;

    logic      accept;
    logic      finish;
    query_t    query;
    slot_wr_t  wr;
    scan_rec_t chain_rec [CACHE_SLOTS+1];
    logic [CACHE_SLOTS:0] chain_val;
    scan_rec_t last;

    slot_idx_t           res_slot;
    tag_t                res_block;
    logic                res_hit;
    logic                res_load;
    logic                res_wb;
    logic [OFFSET_W-1:0] res_offset;
    status_t             res_status;

    function automatic logic [OFFSET_W-1:0] offset_of(input tag_t blk, input logic wh,
                                                      input logic [HDR_W-1:0] hs);
        logic [OFFSET_W-1:0] base;
        base = OFFSET_W'({blk, {BLOCK_SHIFT{1'b0}}});
        return wh ? base + OFFSET_W'(hs) : base;
    endfunction

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign last      = chain_rec[CACHE_SLOTS];
    assign finish    = (state_reg == S_SCAN) && chain_val[CACHE_SLOTS];

    assign query.blk   = blk_reg;
    assign query.count = counter_reg;

    assign chain_rec[0] = '0;
    assign chain_val[0] = inject_reg;

    generate
        for (genvar k = 0; k < CACHE_SLOTS; k++)
        begin : g_cell
            bclt_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cell_idx  (SLOT_W'(k)),
                .query     (query),
                .in_valid  (chain_val[k]),
                .in_rec    (chain_rec[k]),
                .out_valid (chain_val[k+1]),
                .out_rec   (chain_rec[k+1]),
                .wr        (wr)
            );
        end
    endgenerate

    // Decide the result and the slot update from the finished search record.
    always_comb
    begin
        res_slot   = '0;
        res_block  = '0;
        res_hit    = 1'b0;
        res_load   = 1'b0;
        res_wb     = 1'b0;
        res_offset = '0;
        res_status = ST_OK;
        wr         = '0;
        wr.stamp   = counter_reg;
        case (action_reg)
            ACT_GET:
            begin
                if (blk_reg == '0)
                begin
                    res_status = ST_INVALID;
                end
                else if (last.match_found)
                begin
                    res_slot    = last.match_idx;
                    res_block   = blk_reg;
                    res_hit     = 1'b1;
                    wr.en       = 1'b1;
                    wr.idx      = last.match_idx;
                    wr.wr_stamp = 1'b1;
                end
                else if (last.empty_found || last.clean_found)
                begin
                    res_slot    = last.empty_found ? last.empty_idx : last.clean_idx;
                    res_block   = blk_reg;
                    res_load    = 1'b1;
                    res_offset  = offset_of(blk_reg, with_header_reg, header_size_reg);
                    wr.en       = 1'b1;
                    wr.idx      = res_slot;
                    wr.wr_tag   = 1'b1;
                    wr.tag      = blk_reg;
                    wr.wr_dirty = 1'b1;
                    wr.dirty    = 1'b0;
                    wr.wr_stamp = 1'b1;
                end
                else
                begin
                    res_status = ST_FULL;
                end
            end
            ACT_MARK:
            begin
                if (blk_reg == '0)
                begin
                    res_status = ST_INVALID;
                end
                else if (!last.match_found)
                begin
                    res_status = ST_NOT_CACHED;
                end
                else
                begin
                    res_slot    = last.match_idx;
                    res_block   = blk_reg;
                    wr.en       = 1'b1;
                    wr.idx      = last.match_idx;
                    wr.wr_dirty = 1'b1;
                    wr.dirty    = 1'b1;
                    wr.wr_stamp = 1'b1;
                end
            end
            ACT_FLUSH:
            begin
                if (!last.dirty_found)
                begin
                    res_status = ST_NO_DIRTY;
                end
                else
                begin
                    res_slot    = last.dirty_idx;
                    res_block   = last.dirty_tag;
                    res_wb      = 1'b1;
                    res_offset  = offset_of(last.dirty_tag, with_header_reg, header_size_reg);
                    wr.en       = 1'b1;
                    wr.idx      = last.dirty_idx;
                    wr.wr_dirty = 1'b1;
                    wr.dirty    = 1'b0;
                end
            end
            default:
            begin
                res_status = ST_INVALID;
            end
        endcase
        // hold the slot row unless the search has just finished
        wr.en = wr.en && finish;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (chain_val[CACHE_SLOTS])
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            inject_reg      <= 1'b0;
            counter_reg     <= 32'd1;
            with_header_reg <= 1'b0;
            header_size_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            inject_reg <= accept;
            done_reg   <= finish;
            if (finish)
            begin
                counter_reg <= counter_reg + 32'd1;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_WITH_HEADER: with_header_reg <= cfg_data[0];
                    REG_HEADER_SIZE: header_size_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            blk_reg    <= block_number;
        end
        if (finish)
        begin
            slot_reg      <= 4'(res_slot);
            block_out_reg <= res_block;
            hit_reg       <= res_hit;
            load_reg      <= res_load;
            wb_reg        <= res_wb;
            offset_reg    <= res_offset;
            status_reg    <= res_status;
        end
    end

    assign done             = done_reg;
    assign slot             = slot_reg;
    assign block_out        = block_out_reg;
    assign hit              = hit_reg;
    assign load_needed      = load_reg;
    assign writeback_needed = wb_reg;
    assign byte_offset      = offset_reg;
    assign status           = status_reg;

    // at most one search token in the row
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(chain_val))
        else $error("more than one search token in the cell row");

    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_SCAN) && (state_reg == S_IDLE))
        else $error("result strobe without a finished search");

    a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (counter_reg == $past(counter_reg) + 32'd1))
        else $error("use counter did not advance with the item");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (!hit && !load_needed && !writeback_needed
            && (byte_offset == '0) && (slot == '0) && (block_out == '0)))
        else $error("error result carries non-zero fields");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && inject_reg)
        else $error("accepted item did not start a search");

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for block_cache_lru_tags: gets, marks and flushes against a cache predictor.
// Depends on bclt_pkg and the block_cache_lru_tags RTL; needs no files or arguments.
module testbench;
    import bclt_pkg::*;

    localparam logic [1:0] ACT_RESERVED = 2'd3;
    localparam int         POOL_SIZE    = 20;

    typedef struct {
        slot_idx_t     slot;
        tag_t          blk;
        logic          hit;
        logic          load;
        logic          wb;
        logic [25:0]   offset;
        logic [2:0]    status;
    } reply_t;

    // Cache tag predictor and store of outstanding replies.
    class cache_book;
        tag_t             tags   [CACHE_SLOTS];
        bit               dirty  [CACHE_SLOTS];
        stamp_t           stamps [CACHE_SLOTS];
        stamp_t           counter;
        bit               hdr_on;
        logic [HDR_W-1:0] hdr_len;
        reply_t           expected [$];
        int               errors, items, hits, loads, writebacks, fulls, rejects, checked;

        function new();
            foreach (tags[i])
            begin
                tags[i]   = '0;
                dirty[i]  = 1'b0;
                stamps[i] = '0;
            end
            counter = 1;
            hdr_on  = 1'b0;
            hdr_len = '0;
            errors = 0; items = 0; hits = 0; loads = 0;
            writebacks = 0; fulls = 0; rejects = 0; checked = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            if (idx == REG_WITH_HEADER)
                hdr_on = data[0];
            else if (idx == REG_HEADER_SIZE)
                hdr_len = data;
        endfunction

        function logic [25:0] file_offset(tag_t b);
            logic [26:0] full_off;
            full_off = (27'(b) << BLOCK_SHIFT) + (hdr_on ? 27'(hdr_len) : 27'd0);
            return full_off[25:0];
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void note_item(logic [1:0] act, tag_t blk);
            reply_t r;
            int     s;
            stamp_t best;
            stamp_t age;
            r = '{default: '0};
            s = -1;
            best = '0;
            case (act)
                ACT_GET:
                begin
                    if (blk == '0)
                        r.status = ST_INVALID;
                    else
                    begin
                        for (int i = 0; i < CACHE_SLOTS; i++)
                            if (s < 0 && tags[i] == blk) s = i;
                        if (s >= 0)
                        begin
                            stamps[s] = counter;
                            r.slot = slot_idx_t'(s);
                            r.blk  = blk;
                            r.hit  = 1'b1;
                        end
                        else
                        begin
                            for (int i = 0; i < CACHE_SLOTS; i++)
                                if (s < 0 && tags[i] == '0) s = i;
                            // no empty slot: take the oldest clean one, first slot on a tie
                            if (s < 0)
                                for (int i = 0; i < CACHE_SLOTS; i++)
                                    if (!dirty[i])
                                    begin
                                        age = counter - stamps[i];
                                        if (s < 0 || age > best)
                                        begin
                                            s = i;
                                            best = age;
                                        end
                                    end
                            if (s < 0)
                                r.status = ST_FULL;
                            else
                            begin
                                tags[s]   = blk;
                                dirty[s]  = 1'b0;
                                stamps[s] = counter;
                                r.slot   = slot_idx_t'(s);
                                r.blk    = blk;
                                r.load   = 1'b1;
                                r.offset = file_offset(blk);
                            end
                        end
                    end
                end
                ACT_MARK:
                begin
                    if (blk == '0)
                        r.status = ST_INVALID;
                    else
                    begin
                        for (int i = 0; i < CACHE_SLOTS; i++)
                            if (s < 0 && tags[i] == blk) s = i;
                        if (s < 0)
                            r.status = ST_NOT_CACHED;
                        else
                        begin
                            dirty[s]  = 1'b1;
                            stamps[s] = counter;
                            r.slot = slot_idx_t'(s);
                            r.blk  = blk;
                        end
                    end
                end
                ACT_FLUSH:
                begin
                    for (int i = 0; i < CACHE_SLOTS; i++)
                        if (s < 0 && dirty[i]) s = i;
                    if (s < 0)
                        r.status = ST_NO_DIRTY;
                    else
                    begin
                        dirty[s] = 1'b0;
                        r.slot   = slot_idx_t'(s);
                        r.blk    = tags[s];
                        r.wb     = 1'b1;
                        r.offset = file_offset(tags[s]);
                    end
                end
                default:
                    r.status = ST_INVALID;
            endcase
            counter = counter + 1;
            items++;
            if (r.hit) hits++;
            if (r.load) loads++;
            if (r.wb) writebacks++;
            if (r.status == ST_FULL) fulls++;
            if (r.status == ST_INVALID || r.status == ST_NOT_CACHED) rejects++;
            expected.push_back(r);
        endfunction

        function void compare_field(string what, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v)
            begin
                errors++;
                $display("%0t: %s wrong, expected %0h, actual %0h", $time, what, want_v, got_v);
            end
        endfunction

        function void check_result(reply_t got);
            reply_t want;
            if (expected.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual slot %0h status %0h",
                         $time, got.slot, got.status);
                return;
            end
            want = expected.pop_front();
            checked++;
            compare_field("slot", want.slot, got.slot);
            compare_field("block_out", want.blk, got.blk);
            compare_field("hit", want.hit, got.hit);
            compare_field("load_needed", want.load, got.load);
            compare_field("writeback_needed", want.wb, got.wb);
            compare_field("byte_offset", want.offset, got.offset);
            compare_field("status", want.status, got.status);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 start        = 1'b0;
    logic                 busy;
    logic [1:0]           action       = '0;
    logic [15:0]          block_number = '0;
    logic                 done;
    logic [3:0]           slot;
    logic [15:0]          block_out;
    logic                 hit;
    logic                 load_needed;
    logic                 writeback_needed;
    logic [25:0]          byte_offset;
    logic [2:0]           status;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [15:0]          cfg_data     = '0;

    cache_book book = new();
    reply_t    seen;
    tag_t      work_set [POOL_SIZE];
    int        settings_used = 1;

    block_cache_lru_tags uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .action           (action),
        .block_number     (block_number),
        .done             (done),
        .slot             (slot),
        .block_out        (block_out),
        .hit              (hit),
        .load_needed      (load_needed),
        .writeback_needed (writeback_needed),
        .byte_offset      (byte_offset),
        .status           (status),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Capture each result in its one valid cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen.slot   = slot;
            seen.blk    = block_out;
            seen.hit    = hit;
            seen.load   = load_needed;
            seen.wb     = writeback_needed;
            seen.offset = byte_offset;
            seen.status = status;
            book.check_result(seen);
        end
    end

    // Leave start high on return so back-to-back items need no extra edge.
    task automatic send_item(input logic [1:0] act, input tag_t blk);
        start        <= 1'b1;
        action       <= act;
        block_number <= blk;
        do @(posedge clk); while (busy);
        book.note_item(act, blk);
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Hold off until every reply is in, then allow the block to settle.
    task automatic drain();
        start <= 1'b0;
        while (book.pending() > 0) @(posedge clk);
        repeat (CACHE_SLOTS + 4) @(posedge clk);
    endtask

    task automatic configure(input bit on, input logic [15:0] len);
        cfg_valid <= 1'b1;
        cfg_index <= REG_WITH_HEADER;
        cfg_data  <= {15'd0, on};
        do @(posedge clk); while (!cfg_ready);
        book.set_reg(REG_WITH_HEADER, {15'd0, on});
        cfg_index <= REG_HEADER_SIZE;
        cfg_data  <= len;
        do @(posedge clk); while (!cfg_ready);
        book.set_reg(REG_HEADER_SIZE, len);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Mostly traffic on a small working set so that hits, evictions and a full
    // cache come up; every fortieth item may switch to a mark-heavy mix.
    task automatic run_segment(input int count, input int idle_pct);
        logic [1:0] act;
        tag_t       blk;
        bit         heavy;
        int         r;
        heavy = 1'b0;
        foreach (work_set[i])
            work_set[i] = tag_t'($urandom_range(1, 65535));
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                heavy = ($urandom_range(0, 3) == 0);
            r   = $urandom_range(0, 99);
            blk = work_set[$urandom_range(0, POOL_SIZE - 1)];
            if (!heavy)
            begin
                if (r < 45)      act = ACT_GET;
                else if (r < 50)
                begin
                    act = ACT_GET;
                    blk = tag_t'($urandom);
                end
                else if (r < 74) act = ACT_MARK;
                else if (r < 77)
                begin
                    act = ACT_MARK;
                    blk = tag_t'($urandom);
                end
                else if (r < 94)
                begin
                    act = ACT_FLUSH;
                    blk = tag_t'($urandom);
                end
                else if (r < 97)
                begin
                    act = (r[0]) ? ACT_MARK : ACT_GET;
                    blk = '0;
                end
                else
                begin
                    act = ACT_RESERVED;
                    blk = tag_t'($urandom);
                end
            end
            else
            begin
                if (r < 38)      act = ACT_GET;
                else if (r < 85) act = ACT_MARK;
                else if (r < 89)
                begin
                    act = ACT_FLUSH;
                    blk = tag_t'($urandom);
                end
                else if (r < 93)
                begin
                    act = ACT_GET;
                    blk = tag_t'($urandom);
                end
                else if (r < 96)
                begin
                    act = ACT_MARK;
                    blk = '0;
                end
                else
                begin
                    act = ACT_RESERVED;
                    blk = tag_t'($urandom);
                end
            end
            if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
                pause($urandom_range(1, 25));
            send_item(act, blk);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: error codes, hit, mark, flush, fill and one eviction.
        send_item(ACT_GET, 16'd0);
        send_item(ACT_MARK, 16'd0);
        send_item(ACT_RESERVED, 16'h1234);
        send_item(ACT_FLUSH, 16'd0);
        send_item(ACT_MARK, 16'd7);
        send_item(ACT_GET, 16'd1);
        send_item(ACT_GET, 16'hFFFF);
        send_item(ACT_GET, 16'd1);
        send_item(ACT_MARK, 16'hFFFF);
        send_item(ACT_FLUSH, 16'hFFFF);
        send_item(ACT_FLUSH, 16'd0);
        for (int i = 0; i < CACHE_SLOTS - 2; i++)
            send_item(ACT_GET, (i == 0) ? 16'h5555 : (i == 1) ? 16'hAAAA : tag_t'(100 + i));
        send_item(ACT_GET, 16'd200);
        drain();

        configure(1'b1, 16'hFFFF);
        run_segment(240, 9);
        drain();
        run_segment(240, 9);
        drain();

        configure(1'b0, tag_t'($urandom_range(1, 65535)));
        run_segment(470, 73);
        drain();

        configure(1'b1, tag_t'($urandom_range(1, 65534)));
        run_segment(230, 0);
        drain();

        configure(1'b1, 16'd0);
        run_segment(220, 0);
        drain();

        $display("Ran %0d items under %0d header settings: %0d hits, %0d loads, %0d write-backs",
                 book.items, settings_used, book.hits, book.loads, book.writebacks);
        $display("%0d full-cache refusals, %0d rejected items, %0d results checked",
                 book.fulls, book.rejects, book.checked);
        if (book.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
sv/bclt_pkg.sv
sv/bclt_cell.sv
sv/block_cache_lru_tags.sv
tb/testbench.sv
